// ===== design/generational_handle_table_assert.svh =====
`ifndef GENERATIONAL_HANDLE_TABLE_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define GHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ght_pkg.sv =====
package ght_pkg;

    localparam int HANDLE_W = 32;
    localparam int OWNER_W  = 32;
    localparam int LIMIT_W  = 11;
    localparam int CFG_W    = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

    localparam logic [1:0] CMD_ACQUIRE = 2'd0;
    localparam logic [1:0] CMD_DISCARD = 2'd1;
    localparam logic [1:0] CMD_LOOKUP  = 2'd2;
    localparam logic [1:0] CMD_NEXT    = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_NULL = 2'd3;

    localparam logic REG_ENTRY_LIMIT = 1'b0;
    localparam logic REG_START_VALUE = 1'b1;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [HANDLE_W-1:0] handle;
        logic [OWNER_W-1:0]  owner;
    } t_req;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic [OWNER_W-1:0]  owner_out;
        logic [1:0]          status;
    } t_rsp;

endpackage

// ===== design/generational_handle_table.sv =====
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+-------------------------
// request   | in        | start && !busy       | i_req  (ght_pkg::t_req)
// result    | out       | o_valid, one cycle   | o_rsp  (ght_pkg::t_rsp)
// config    | in        | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// one transaction at a time; busy is high in the pop, check, tail and scan states and drops
// as the result strobe rises. acquire answers from idle (new entry, null owner, full) without
// raising busy, or via the pop state (reuse); lookup goes through the check state; discard
// through check, then the tail state when the free list tail has to be relinked; next scans
// from the entry after the given index up to the lower of the limit and the fresh index, one
// owner/handle memory read per cycle. entries at or above the fresh index count as never
// written and read as zero, so the memories get no clearing pass. results cannot be stalled.
`include "generational_handle_table_assert.svh"

module generational_handle_table #(
    parameter int INDEX_BITS = 10,
    parameter int OWNER_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  ght_pkg::t_req              i_req,
    output logic                       o_valid,
    output ght_pkg::t_rsp              o_rsp,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [ght_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int DEPTH = 1 << INDEX_BITS;
    localparam int LW    = (INDEX_BITS + 1 > ght_pkg::LIMIT_W) ? INDEX_BITS + 1
                                                                : ght_pkg::LIMIT_W;
    localparam int GW    = ght_pkg::HANDLE_W - INDEX_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_CHECK,
        S_TAIL,
        S_SCAN
    } t_state;

    // storage
    logic [OWNER_BITS-1:0]        owner_mem  [DEPTH];
    logic [ght_pkg::HANDLE_W-1:0] handle_mem [DEPTH];

    // control and datapath registers
    t_state                       r_state, n_state;
    logic [1:0]                   r_cmd, n_cmd;
    logic [ght_pkg::HANDLE_W-1:0] r_handle, n_handle;
    logic [OWNER_BITS-1:0]        r_owner, n_owner;
    logic [ght_pkg::LIMIT_W-1:0]  r_entry_limit;
    logic [ght_pkg::CFG_W-1:0]    r_start_value;
    logic [INDEX_BITS:0]          r_fresh, n_fresh;
    logic [INDEX_BITS-1:0]        r_free_head, n_free_head;
    logic [INDEX_BITS-1:0]        r_free_tail, n_free_tail;
    logic [INDEX_BITS:0]          r_addr, n_addr;
    logic                         r_pend, n_pend;
    logic                         r_rd_zero, n_rd_zero;
    logic [OWNER_BITS-1:0]        r_rd_owner;
    logic [ght_pkg::HANDLE_W-1:0] r_rd_handle;
    logic                         n_valid;
    ght_pkg::t_rsp                n_rsp;

    // memory port controls
    logic                         w_rd_en;
    logic [INDEX_BITS-1:0]        w_rd_addr;
    logic                         w_own_we;
    logic                         w_hnd_we;
    logic [INDEX_BITS-1:0]        w_wr_addr;
    logic [OWNER_BITS-1:0]        w_own_wdata;
    logic [ght_pkg::HANDLE_W-1:0] w_hnd_wdata;

    // helpers
    logic                         w_accept;
    logic [INDEX_BITS-1:0]        w_in_idx;
    logic                         w_in_live;
    logic [OWNER_BITS-1:0]        w_in_own;
    logic [LW-1:0]                w_lim_ext;
    logic [LW-1:0]                w_eff_lim;
    logic [LW-1:0]                w_fresh_ext;
    logic [LW-1:0]                w_scan_end;
    logic [OWNER_BITS-1:0]        w_cur_owner;
    logic [ght_pkg::HANDLE_W-1:0] w_cur_handle;
    logic                         w_match;
    logic [INDEX_BITS-1:0]        w_idx;
    logic [GW-1:0]                w_gen_next;
    logic                         w_tail_rd;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_in_idx = i_req.handle[INDEX_BITS-1:0];
    assign w_in_own = OWNER_BITS'(i_req.owner);

    assign w_lim_ext   = LW'(r_entry_limit);
    assign w_eff_lim   = (w_lim_ext > LW'(DEPTH)) ? LW'(DEPTH) : w_lim_ext;
    assign w_fresh_ext = LW'(r_fresh);
    assign w_scan_end  = (w_eff_lim < w_fresh_ext) ? w_eff_lim : w_fresh_ext;
    // entry zero and entries not yet handed out were never written
    assign w_in_live   = (w_in_idx != '0) && (LW'(w_in_idx) < w_fresh_ext);

    assign w_cur_owner  = r_rd_zero ? '0 : r_rd_owner;
    assign w_cur_handle = r_rd_zero ? '0 : r_rd_handle;
    assign w_match      = (w_cur_owner != '0) && (w_cur_handle == r_handle);
    assign w_idx        = r_handle[INDEX_BITS-1:0];
    assign w_gen_next   = r_handle[ght_pkg::HANDLE_W-1:INDEX_BITS] + 1'b1;
    assign w_tail_rd    = (r_state == S_CHECK) && (r_cmd == ght_pkg::CMD_DISCARD)
                          && w_match && (r_free_head != '0);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_handle    = r_handle;
        n_owner     = r_owner;
        n_fresh     = r_fresh;
        n_free_head = r_free_head;
        n_free_tail = r_free_tail;
        n_addr      = r_addr;
        n_pend      = r_pend;
        n_rd_zero   = r_rd_zero;
        n_valid     = 1'b0;
        n_rsp       = o_rsp;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_addr[INDEX_BITS-1:0];
        w_own_we    = 1'b0;
        w_hnd_we    = 1'b0;
        w_wr_addr   = w_idx;
        w_own_wdata = '0;
        w_hnd_wdata = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd    = i_req.cmd;
                    n_handle = i_req.handle;
                    n_owner  = w_in_own;
                    case (i_req.cmd)
                        ght_pkg::CMD_ACQUIRE: begin
                            if (w_in_own == '0) begin
                                n_valid = 1'b1;
                                n_rsp   = '{handle_out: '0, owner_out: '0,
                                            status: ght_pkg::ST_NULL};
                            end else if (r_free_head != '0) begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = r_free_head;
                                n_rd_zero = 1'b0;
                                n_state   = S_POP;
                            end else if (w_fresh_ext < w_eff_lim) begin
                                w_own_we    = 1'b1;
                                w_hnd_we    = 1'b1;
                                w_wr_addr   = r_fresh[INDEX_BITS-1:0];
                                w_own_wdata = w_in_own;
                                w_hnd_wdata = {r_start_value[ght_pkg::HANDLE_W-1:INDEX_BITS],
                                               r_fresh[INDEX_BITS-1:0]};
                                n_fresh     = r_fresh + 1'b1;
                                n_valid     = 1'b1;
                                n_rsp       = '{handle_out: w_hnd_wdata, owner_out: '0,
                                                status: ght_pkg::ST_OK};
                            end else begin
                                n_valid = 1'b1;
                                n_rsp   = '{handle_out: '0, owner_out: '0,
                                            status: ght_pkg::ST_FULL};
                            end
                        end
                        ght_pkg::CMD_DISCARD, ght_pkg::CMD_LOOKUP: begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = w_in_idx;
                            n_rd_zero = !w_in_live;
                            n_state   = S_CHECK;
                        end
                        default: begin
                            n_addr  = {1'b0, w_in_idx} + 1'b1;
                            n_pend  = 1'b0;
                            n_state = S_SCAN;
                        end
                    endcase
                end
            end
            S_POP: begin
                // the popped entry's stored handle holds the link in its index bits
                w_own_we    = 1'b1;
                w_hnd_we    = 1'b1;
                w_wr_addr   = r_free_head;
                w_own_wdata = r_owner;
                w_hnd_wdata = {r_rd_handle[ght_pkg::HANDLE_W-1:INDEX_BITS], r_free_head};
                n_free_head = r_rd_handle[INDEX_BITS-1:0];
                n_valid     = 1'b1;
                n_rsp       = '{handle_out: w_hnd_wdata, owner_out: '0,
                                status: ght_pkg::ST_OK};
                n_state     = S_IDLE;
            end
            S_CHECK: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                if (r_cmd == ght_pkg::CMD_LOOKUP) begin
                    if (w_match) begin
                        n_rsp = '{handle_out: r_handle,
                                  owner_out: ght_pkg::OWNER_W'(w_cur_owner),
                                  status: ght_pkg::ST_OK};
                    end else begin
                        n_rsp = '{handle_out: '0, owner_out: '0, status: ght_pkg::ST_MISS};
                    end
                end else if (!w_match) begin
                    n_rsp = '{handle_out: '0, owner_out: '0, status: ght_pkg::ST_MISS};
                end else begin
                    w_own_we    = 1'b1;
                    w_hnd_we    = 1'b1;
                    w_wr_addr   = w_idx;
                    w_own_wdata = '0;
                    w_hnd_wdata = {w_gen_next, {INDEX_BITS{1'b0}}};
                    n_rsp       = '{handle_out: '0, owner_out: '0, status: ght_pkg::ST_OK};
                    if (r_free_head == '0) begin
                        n_free_head = w_idx;
                        n_free_tail = w_idx;
                    end else begin
                        // relink the old tail next cycle
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_free_tail;
                        n_rd_zero = 1'b0;
                        n_valid   = 1'b0;
                        n_state   = S_TAIL;
                    end
                end
            end
            S_TAIL: begin
                w_hnd_we    = 1'b1;
                w_wr_addr   = r_free_tail;
                w_hnd_wdata = r_rd_handle | {{GW{1'b0}}, w_idx};
                n_free_tail = w_idx;
                n_valid     = 1'b1;
                n_rsp       = '{handle_out: '0, owner_out: '0, status: ght_pkg::ST_OK};
                n_state     = S_IDLE;
            end
            S_SCAN: begin
                // one read issued per cycle, data checked the cycle after
                if (r_pend && (r_rd_owner != '0)) begin
                    n_valid = 1'b1;
                    n_rsp   = '{handle_out: r_rd_handle,
                                owner_out: ght_pkg::OWNER_W'(r_rd_owner),
                                status: ght_pkg::ST_OK};
                    n_state = S_IDLE;
                end else if (LW'(r_addr) < w_scan_end) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_addr[INDEX_BITS-1:0];
                    n_rd_zero = 1'b0;
                    n_addr    = r_addr + 1'b1;
                    n_pend    = 1'b1;
                end else begin
                    n_valid = 1'b1;
                    n_rsp   = '{handle_out: '0, owner_out: '0, status: ght_pkg::ST_MISS};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_own_we) begin
            owner_mem[w_wr_addr] <= w_own_wdata;
        end
        if (w_rd_en) begin
            r_rd_owner <= owner_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hnd_we) begin
            handle_mem[w_wr_addr] <= w_hnd_wdata;
        end
        if (w_rd_en) begin
            r_rd_handle <= handle_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_fresh       <= (INDEX_BITS + 1)'(1);
            r_free_head   <= '0;
            r_free_tail   <= '0;
            r_entry_limit <= ght_pkg::LIMIT_RESET;
            r_start_value <= '0;
            r_pend        <= 1'b0;
            o_valid       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fresh     <= n_fresh;
            r_free_head <= n_free_head;
            r_free_tail <= n_free_tail;
            r_pend      <= n_pend;
            o_valid     <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ght_pkg::REG_ENTRY_LIMIT: r_entry_limit <= i_cfg_data[ght_pkg::LIMIT_W-1:0];
                    ght_pkg::REG_START_VALUE: r_start_value <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_cmd     <= n_cmd;
        r_handle  <= n_handle;
        r_owner   <= n_owner;
        r_addr    <= n_addr;
        r_rd_zero <= n_rd_zero;
        o_rsp     <= n_rsp;
    end

    `GHT_ASSERT_NOW(a_fresh_nonzero, 1'b1, r_fresh != '0, "fresh index dropped to zero")
    `GHT_ASSERT_NOW(a_head_handed_out, r_free_head != '0,
        LW'(r_free_head) < LW'(r_fresh), "free list head beyond handed-out entries")
    `GHT_ASSERT_NOW(a_tail_not_discarded, w_tail_rd, r_free_tail != w_idx,
        "free list tail equals the entry being discarded")
    `GHT_ASSERT_NEXT(a_tail_follows_check, w_tail_rd, r_state == S_TAIL && !o_valid,
        "tail relink did not follow discard check")
    `GHT_ASSERT_NOW(a_result_ends_work, o_valid && busy, $past(w_rd_en),
        "result strobe while still busy without a pending read")

endmodule
